### rtl/stsg_pkg.sv
// shared constants, register indexes and glyph rom for the stroke text generator
`default_nettype none

package stsg_pkg;

    localparam int COORD_BITS  = 16;
    localparam int GLYPH_WIDTH  = 2;
    localparam int GLYPH_HEIGHT = 2;
    localparam int MAX_STROKES  = 6;
    localparam int GLYPH_COUNT  = 36;
    localparam int STROKE_BITS  = 8;
    localparam int ROW_BITS     = MAX_STROKES * STROKE_BITS;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [5:0]            glyph_idx_t;
    typedef logic [2:0]            stroke_idx_t;
    typedef logic [STROKE_BITS-1:0] stroke_t;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_MARGIN_X  = 3'd0,
        REG_MARGIN_Y  = 3'd1,
        REG_SCALE     = 3'd2,
        REG_TAB_WIDTH = 3'd3,
        REG_ORIGIN_X  = 3'd4,
        REG_ORIGIN_Y  = 3'd5
    } reg_index_t;

    // cursor memory entries
    localparam logic CUR_ENTRY_X = 1'b0;
    localparam logic CUR_ENTRY_Y = 1'b1;

    localparam stroke_t NO_STROKE = 8'h00;

    // pack one stroke: start (a,b), end (c,d) on the 3x3 grid
    function automatic stroke_t sk(input int a, input int b, input int c, input int d);
        logic [1:0] pa, pb, pc, pd;
        pa = a[1:0];
        pb = b[1:0];
        pc = c[1:0];
        pd = d[1:0];
        return {pa, pb, pc, pd};
    endfunction

    // number of strokes per glyph; letters at 0..25, digits at 26..35
    function automatic stroke_idx_t glyph_count(input glyph_idx_t g);
        stroke_idx_t n;
        case (g)
            6'd0:  n = 3'd4;  6'd1:  n = 3'd6;  6'd2:  n = 3'd3;  6'd3:  n = 3'd5;
            6'd4:  n = 3'd4;  6'd5:  n = 3'd3;  6'd6:  n = 3'd5;  6'd7:  n = 3'd3;
            6'd8:  n = 3'd3;  6'd9:  n = 3'd3;  6'd10: n = 3'd3;  6'd11: n = 3'd2;
            6'd12: n = 3'd4;  6'd13: n = 3'd3;  6'd14: n = 3'd4;  6'd15: n = 3'd4;
            6'd16: n = 3'd6;  6'd17: n = 3'd5;  6'd18: n = 3'd5;  6'd19: n = 3'd2;
            6'd20: n = 3'd3;  6'd21: n = 3'd2;  6'd22: n = 3'd4;  6'd23: n = 3'd2;
            6'd24: n = 3'd3;  6'd25: n = 3'd4;  6'd26: n = 3'd5;  6'd27: n = 3'd3;
            6'd28: n = 3'd5;  6'd29: n = 3'd5;  6'd30: n = 3'd3;  6'd31: n = 3'd5;
            6'd32: n = 3'd5;  6'd33: n = 3'd2;  6'd34: n = 3'd5;  6'd35: n = 3'd4;
            default: n = 3'd1;
        endcase
        return n;
    endfunction

    // stroke list of one glyph, first stroke in the top byte
    function automatic logic [ROW_BITS-1:0] glyph_row(input glyph_idx_t g);
        logic [ROW_BITS-1:0] r;
        case (g)
            6'd0:  r = {sk(0,0,0,2), sk(2,0,2,2), sk(0,0,2,0), sk(0,1,2,1), NO_STROKE, NO_STROKE};
            6'd1:  r = {sk(0,0,0,2), sk(2,1,2,2), sk(0,0,2,0), sk(0,1,2,1), sk(0,2,2,2),
                        sk(1,1,2,0)};
            6'd2:  r = {sk(0,0,0,2), sk(0,0,2,0), sk(0,2,2,2), NO_STROKE, NO_STROKE, NO_STROKE};
            6'd3:  r = {sk(0,0,0,2), sk(2,0,2,1), sk(0,0,2,0), sk(0,2,1,2), sk(1,2,2,1),
                        NO_STROKE};
            6'd4:  r = {sk(0,0,0,2), sk(0,0,2,0), sk(0,1,1,1), sk(0,2,2,2), NO_STROKE, NO_STROKE};
            6'd5:  r = {sk(0,0,0,2), sk(0,0,2,0), sk(0,1,1,1), NO_STROKE, NO_STROKE, NO_STROKE};
            6'd6:  r = {sk(0,0,0,2), sk(2,1,2,2), sk(0,0,2,0), sk(1,1,2,1), sk(0,2,2,2),
                        NO_STROKE};
            6'd7:  r = {sk(0,0,0,2), sk(2,0,2,2), sk(0,1,2,1), NO_STROKE, NO_STROKE, NO_STROKE};
            6'd8:  r = {sk(1,0,1,2), sk(0,0,2,0), sk(0,2,2,2), NO_STROKE, NO_STROKE, NO_STROKE};
            6'd9:  r = {sk(0,1,0,2), sk(2,0,2,2), sk(0,2,2,2), NO_STROKE, NO_STROKE, NO_STROKE};
            6'd10: r = {sk(0,0,0,2), sk(0,1,2,0), sk(0,1,2,2), NO_STROKE, NO_STROKE, NO_STROKE};
            6'd11: r = {sk(0,0,0,2), sk(0,2,2,2), NO_STROKE, NO_STROKE, NO_STROKE, NO_STROKE};
            6'd12: r = {sk(0,0,0,2), sk(2,0,2,2), sk(0,0,1,2), sk(1,2,2,0), NO_STROKE, NO_STROKE};
            6'd13: r = {sk(0,0,0,2), sk(2,0,2,2), sk(0,0,2,2), NO_STROKE, NO_STROKE, NO_STROKE};
            6'd14: r = {sk(0,0,0,2), sk(2,0,2,2), sk(0,0,2,0), sk(0,2,2,2), NO_STROKE, NO_STROKE};
            6'd15: r = {sk(0,0,0,2), sk(2,0,2,1), sk(0,0,2,0), sk(0,1,2,1), NO_STROKE, NO_STROKE};
            6'd16: r = {sk(0,0,0,2), sk(2,0,2,1), sk(0,0,2,0), sk(0,2,1,2), sk(1,1,2,2),
                        sk(1,2,2,1)};
            6'd17: r = {sk(0,0,0,2), sk(2,0,2,1), sk(0,0,2,0), sk(0,1,2,1), sk(1,1,2,2),
                        NO_STROKE};
            6'd18: r = {sk(0,0,0,1), sk(2,1,2,2), sk(0,0,2,0), sk(0,1,2,1), sk(0,2,2,2),
                        NO_STROKE};
            6'd19: r = {sk(1,0,1,2), sk(0,0,2,0), NO_STROKE, NO_STROKE, NO_STROKE, NO_STROKE};
            6'd20: r = {sk(0,0,0,2), sk(2,0,2,2), sk(0,2,2,2), NO_STROKE, NO_STROKE, NO_STROKE};
            6'd21: r = {sk(0,0,1,2), sk(1,2,2,0), NO_STROKE, NO_STROKE, NO_STROKE, NO_STROKE};
            6'd22: r = {sk(0,0,0,2), sk(2,0,2,2), sk(0,2,1,1), sk(1,1,2,2), NO_STROKE, NO_STROKE};
            6'd23: r = {sk(0,0,2,2), sk(0,2,2,0), NO_STROKE, NO_STROKE, NO_STROKE, NO_STROKE};
            6'd24: r = {sk(1,1,1,2), sk(0,0,1,1), sk(1,1,2,0), NO_STROKE, NO_STROKE, NO_STROKE};
            6'd25: r = {sk(0,0,2,0), sk(0,1,2,1), sk(0,2,2,2), sk(0,2,2,0), NO_STROKE, NO_STROKE};
            6'd26: r = {sk(0,0,0,2), sk(2,0,2,2), sk(0,0,2,0), sk(0,2,2,2), sk(0,2,2,0),
                        NO_STROKE};
            6'd27: r = {sk(1,0,1,2), sk(0,2,2,2), sk(0,1,1,0), NO_STROKE, NO_STROKE, NO_STROKE};
            6'd28: r = {sk(0,1,0,2), sk(2,0,2,1), sk(0,0,2,0), sk(0,1,2,1), sk(0,2,2,2),
                        NO_STROKE};
            6'd29: r = {sk(2,1,2,2), sk(0,0,2,0), sk(1,1,2,1), sk(0,2,2,2), sk(1,1,2,0),
                        NO_STROKE};
            6'd30: r = {sk(1,0,1,2), sk(0,1,2,1), sk(0,1,1,0), NO_STROKE, NO_STROKE, NO_STROKE};
            6'd31: r = {sk(0,0,0,1), sk(0,0,2,0), sk(0,1,2,1), sk(0,2,1,2), sk(1,2,2,1),
                        NO_STROKE};
            6'd32: r = {sk(0,0,0,2), sk(2,1,2,2), sk(0,0,2,0), sk(0,1,2,1), sk(0,2,2,2),
                        NO_STROKE};
            6'd33: r = {sk(0,0,2,0), sk(1,2,2,0), NO_STROKE, NO_STROKE, NO_STROKE, NO_STROKE};
            6'd34: r = {sk(0,0,0,2), sk(2,0,2,2), sk(0,0,2,0), sk(0,1,2,1), sk(0,2,2,2),
                        NO_STROKE};
            6'd35: r = {sk(0,0,0,1), sk(2,0,2,2), sk(0,0,2,0), sk(0,1,2,1), NO_STROKE, NO_STROKE};
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/stroke_text_segment_generator_core.sv
// top level of the stroke text segment generator: sequencer, cursor memory and output register
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+-------------------------------------------
//  in       | input     | in_valid / in_stall | char_code
//  out      | output    | out_valid/out_stall | seg_kind, start_x, start_y, end_x, end_y, last
//  cfg      | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// sequence: a glyph is accepted, its cursor x and y are read from the cursor memory in turn,
//   it is decoded, its strokes go out one stroke per cycle while out_stall does not hold them,
//   then one write-back follows. x and y are read in turn as the cursor memory has one read port
// reset: asynchronous, active low; cursor memory entries read as zero until first written
// stalls: out_stall holds the output register; strokes wait in place while it is full and stalled.
//   in_stall is high while a character transaction is in progress or a register write is offered
`default_nettype none

module stroke_text_segment_generator_core
    import stsg_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // character input
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [7:0]            char_code,
    // segment output
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic                       seg_kind,
    output logic [COORD_BITS-1:0]      start_x,
    output logic [COORD_BITS-1:0]      start_y,
    output logic [COORD_BITS-1:0]      end_x,
    output logic [COORD_BITS-1:0]      end_y,
    output logic                       last,
    // configuration writes
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [2:0]            cfg_index,
    input  wire logic [COORD_BITS-1:0] cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_X,
        S_RD_Y,
        S_EXEC,
        S_TAB,
        S_EMIT,
        S_RECT,
        S_WB_X,
        S_WB_Y
    } state_t;

    typedef enum logic [2:0] {
        CK_GLYPH,
        CK_SPACE,
        CK_TAB,
        CK_NEWLINE,
        CK_BACKSPACE,
        CK_OTHER
    } char_kind_t;

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] DIGIT_BASE = 8'd26;

    // configuration registers
    logic [7:0]  margin_x_reg, margin_y_reg, tab_width_reg;
    logic [3:0]  scale_reg;
    coord_t      origin_x_reg;

    // sequencer state
    state_t      state_reg;
    char_kind_t  kind_reg;
    glyph_idx_t  glyph_reg;
    stroke_idx_t count_reg;
    stroke_idx_t stroke_index_reg;
    coord_t      cur_x_reg, cur_y_reg;
    coord_t      new_x_reg, new_y_reg;
    coord_t      adv_reg;
    coord_t      tab_adv_reg;
    logic        x_valid_reg, y_valid_reg;

    // output register
    logic        out_valid_reg;
    logic        seg_kind_reg, last_reg;
    coord_t      start_x_reg, start_y_reg, end_x_reg, end_y_reg;

    // decode of the incoming character
    char_kind_t  kind_in;
    glyph_idx_t  glyph_in;

    // cursor memory port
    logic        ram_we;
    logic        ram_waddr;
    coord_t      ram_wdata;
    logic        ram_raddr;
    coord_t      ram_rdata;
    coord_t      cursor_rd;

    logic        in_accept;
    logic        cfg_accept;
    logic        out_free;
    logic        out_load;

    // arithmetic
    coord_t                adv_calc;
    coord_t                line_adv;
    coord_t                glyph_h;
    logic [ROW_BITS-1:0]   row;
    stroke_t               stroke;
    logic [5:0]            px1, py1, px2, py2;
    logic                  stroke_last;

    assign in_accept  = in_valid && !in_stall;
    assign cfg_ready  = (state_reg == S_IDLE);
    assign cfg_accept = cfg_valid && cfg_ready;
    // a pending register write goes first, so a character never shares its edge
    assign in_stall   = (state_reg != S_IDLE) || cfg_valid;
    assign out_free   = !out_valid_reg || !out_stall;
    assign out_load   = out_free && ((state_reg == S_EMIT) || (state_reg == S_RECT));

    // character classification
    always_comb
    begin
        kind_in  = CK_OTHER;
        glyph_in = '0;
        if (char_code >= CH_UPPER_A && char_code <= CH_UPPER_Z)
        begin
            kind_in  = CK_GLYPH;
            glyph_in = 6'(char_code - CH_UPPER_A);
        end
        else if (char_code >= CH_LOWER_A && char_code <= CH_LOWER_Z)
        begin
            kind_in  = CK_GLYPH;
            glyph_in = 6'(char_code - CH_LOWER_A);
        end
        else if (char_code >= CH_DIGIT_0 && char_code <= CH_DIGIT_9)
        begin
            kind_in  = CK_GLYPH;
            glyph_in = 6'(char_code - CH_DIGIT_0 + DIGIT_BASE);
        end
        else
        begin
            unique case (char_code)
                CH_SPACE: kind_in = CK_SPACE;
                CH_TAB:   kind_in = CK_TAB;
                CH_NL:    kind_in = CK_NEWLINE;
                CH_BS:    kind_in = CK_BACKSPACE;
                default:  kind_in = CK_OTHER;
            endcase
        end
    end

    // cell advance and line advance, wrapping at the coordinate width
    assign adv_calc = COORD_BITS'(GLYPH_WIDTH) * COORD_BITS'(scale_reg)
                    + COORD_BITS'(margin_x_reg) - COORD_BITS'(1);
    assign glyph_h  = COORD_BITS'(GLYPH_HEIGHT) * COORD_BITS'(scale_reg);
    assign line_adv = glyph_h + COORD_BITS'(margin_y_reg) - COORD_BITS'(1);

    // current stroke from the glyph rom, scaled on the grid
    assign row    = glyph_row(glyph_reg);
    assign stroke = row[(MAX_STROKES - 1 - int'(stroke_index_reg)) * STROKE_BITS +: STROKE_BITS];
    assign px1    = {4'b0, stroke[7:6]} * {2'b0, scale_reg};
    assign py1    = {4'b0, stroke[5:4]} * {2'b0, scale_reg};
    assign px2    = {4'b0, stroke[3:2]} * {2'b0, scale_reg};
    assign py2    = {4'b0, stroke[1:0]} * {2'b0, scale_reg};
    assign stroke_last = (stroke_index_reg + 3'd1 == count_reg);

    // cursor memory access: reads in the fetch states, writes from config or write-back
    always_comb
    begin
        ram_raddr = (state_reg == S_RD_X) ? CUR_ENTRY_Y : CUR_ENTRY_X;
        ram_we    = 1'b0;
        ram_waddr = CUR_ENTRY_X;
        ram_wdata = new_x_reg;
        if (state_reg == S_WB_X)
        begin
            ram_we = 1'b1;
        end
        else if (state_reg == S_WB_Y)
        begin
            ram_we    = 1'b1;
            ram_waddr = CUR_ENTRY_Y;
            ram_wdata = new_y_reg;
        end
        else if (cfg_accept && cfg_index == REG_ORIGIN_X)
        begin
            ram_we    = 1'b1;
            ram_wdata = cfg_data;
        end
        else if (cfg_accept && cfg_index == REG_ORIGIN_Y)
        begin
            ram_we    = 1'b1;
            ram_waddr = CUR_ENTRY_Y;
            ram_wdata = cfg_data;
        end
    end

    // an entry never written reads as the reset cursor, zero
    always_comb
    begin
        if (state_reg == S_RD_X)
        begin
            cursor_rd = x_valid_reg ? ram_rdata : '0;
        end
        else
        begin
            cursor_rd = y_valid_reg ? ram_rdata : '0;
        end
    end

    stsg_ram #(
        .WIDTH (COORD_BITS),
        .DEPTH (2)
    ) u_cursor_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            margin_x_reg  <= 8'd1;
            margin_y_reg  <= 8'd1;
            scale_reg     <= 4'd1;
            tab_width_reg <= 8'd1;
            origin_x_reg  <= '0;
        end
        else if (cfg_accept)
        begin
            case (cfg_index)
                REG_MARGIN_X:  margin_x_reg  <= cfg_data[7:0];
                REG_MARGIN_Y:  margin_y_reg  <= cfg_data[7:0];
                REG_SCALE:     scale_reg     <= cfg_data[3:0];
                REG_TAB_WIDTH: tab_width_reg <= cfg_data[7:0];
                REG_ORIGIN_X:  origin_x_reg  <= cfg_data;
                // origin y only loads the cursor memory entry
                REG_ORIGIN_Y:  ;
                default: ;
            endcase
        end
    end

    // valid marks for the two cursor entries
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_valid_reg <= 1'b0;
            y_valid_reg <= 1'b0;
        end
        else if (ram_we)
        begin
            if (ram_waddr == CUR_ENTRY_X)
            begin
                x_valid_reg <= 1'b1;
            end
            else
            begin
                y_valid_reg <= 1'b1;
            end
        end
    end

    // sequencer: fetch cursor, act on the character, emit, write back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            kind_reg         <= CK_OTHER;
            stroke_index_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        kind_reg  <= kind_in;
                        glyph_reg <= glyph_in;
                        count_reg <= glyph_count(glyph_in);
                        state_reg <= S_RD_X;
                    end
                end
                S_RD_X:
                begin
                    cur_x_reg <= cursor_rd;
                    adv_reg   <= adv_calc;
                    state_reg <= S_RD_Y;
                end
                S_RD_Y:
                begin
                    cur_y_reg <= cursor_rd;
                    state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    stroke_index_reg <= '0;
                    unique case (kind_reg)
                        CK_GLYPH:
                        begin
                            state_reg <= S_EMIT;
                        end
                        CK_SPACE:
                        begin
                            new_x_reg <= cur_x_reg + adv_reg;
                            state_reg <= S_WB_X;
                        end
                        CK_TAB:
                        begin
                            tab_adv_reg <= COORD_BITS'(adv_reg * COORD_BITS'(tab_width_reg));
                            state_reg   <= S_TAB;
                        end
                        CK_NEWLINE:
                        begin
                            new_x_reg <= origin_x_reg;
                            new_y_reg <= cur_y_reg + line_adv;
                            state_reg <= S_WB_X;
                        end
                        CK_BACKSPACE:
                        begin
                            new_x_reg <= cur_x_reg - adv_reg;
                            state_reg <= S_RECT;
                        end
                        default:
                        begin
                            state_reg <= S_IDLE;
                        end
                    endcase
                end
                S_TAB:
                begin
                    new_x_reg <= cur_x_reg + tab_adv_reg;
                    state_reg <= S_WB_X;
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        seg_kind_reg  <= 1'b0;
                        start_x_reg   <= cur_x_reg + COORD_BITS'(px1);
                        start_y_reg   <= cur_y_reg + COORD_BITS'(py1);
                        end_x_reg     <= cur_x_reg + COORD_BITS'(px2);
                        end_y_reg     <= cur_y_reg + COORD_BITS'(py2);
                        last_reg      <= stroke_last;
                        if (stroke_last)
                        begin
                            stroke_index_reg <= '0;
                            new_x_reg        <= cur_x_reg + adv_reg;
                            state_reg        <= S_WB_X;
                        end
                        else
                        begin
                            stroke_index_reg <= stroke_index_reg + 3'd1;
                        end
                    end
                end
                S_RECT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        seg_kind_reg  <= 1'b1;
                        start_x_reg   <= new_x_reg;
                        start_y_reg   <= cur_y_reg;
                        end_x_reg     <= new_x_reg + adv_reg;
                        end_y_reg     <= cur_y_reg + glyph_h;
                        last_reg      <= 1'b1;
                        state_reg     <= S_WB_X;
                    end
                end
                S_WB_X:
                begin
                    // newline also moves y; the next fetch cannot start before this ends
                    state_reg <= (kind_reg == CK_NEWLINE) ? S_WB_Y : S_IDLE;
                end
                S_WB_Y:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign seg_kind  = seg_kind_reg;
    assign start_x   = start_x_reg;
    assign start_y   = start_y_reg;
    assign end_x     = end_x_reg;
    assign end_y     = end_y_reg;
    assign last      = last_reg;

    // stroke counter stays inside the glyph while emitting
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (stroke_index_reg < count_reg))
        else $error("stroke index ran past glyph stroke count");

    // the final segment of a character is always followed by the cursor write-back
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && ((state_reg == S_RECT) || stroke_last)) |=> (state_reg == S_WB_X))
        else $error("final segment not followed by cursor write-back");

    // write-back marks the x entry as holding a real cursor
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WB_X) |=> x_valid_reg)
        else $error("cursor x entry not marked after write-back");

    // a clear rectangle is always the only and final result of its character
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && seg_kind_reg) |-> last_reg)
        else $error("clear rectangle without last mark");

    // memory is only written from a write-back state or from an accepted config transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ((state_reg == S_WB_X) || (state_reg == S_WB_Y) || cfg_accept))
        else $error("unexpected cursor memory write");

endmodule

`default_nettype wire

### rtl/stsg_ram.sv
// generic single-write, single-read synchronous ram with registered read data
`default_nettype none

module stsg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
